// ----- hdl/axis_position_counter_bank_defines.svh -----
// Assertion macros shared by the checker files of the axis position counter bank.
// No dependencies; include by bare file name.
`ifndef AXIS_POSITION_COUNTER_BANK_DEFINES_SVH
`define AXIS_POSITION_COUNTER_BANK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define APCB_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apcb assertion failed");

// Next-cycle implication, disabled during reset.
`define APCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apcb assertion failed");

// Next-cycle implication that is checked through reset as well.
`define APCB_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("apcb assertion failed");

`endif

// ----- hdl/apcb_pkg.sv -----
// Types, codes and constants of the axis position counter bank.
// No dependencies; used by the top level and the checker.
package apcb_pkg;

  localparam int NUM_AXES    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int SCALE_W     = 32;
  localparam int PROD_W      = COUNT_WIDTH + SCALE_W;
  localparam int MAG_W       = 20;
  localparam int POS_W       = 21;
  localparam int ADDR_W      = 4;

  localparam logic [1:0] ROTARY_AXIS = 2'd3;

  // Zero scale stands for 0.1 display LSB per count on linear axes and 0.01 on the rotary axis, in Q16.16 display LSBs.
  localparam logic [SCALE_W-1:0] MIN_SCALE_LINEAR = SCALE_W'(6554);
  localparam logic [SCALE_W-1:0] MIN_SCALE_ROTARY = SCALE_W'(655);

  localparam logic [MAG_W-1:0]  POS_LIMIT     = MAG_W'(999999);
  localparam logic [PROD_W-1:0] SAT_THRESHOLD = PROD_W'(64'd65536000000);

  typedef enum logic [2:0] {
    KIND_INC,
    KIND_DEC,
    KIND_ZERO,
    KIND_LOAD,
    KIND_CLEAR,
    KIND_READ
  } kind_t;

  typedef enum logic [1:0] {
    FLAG_CLEAR,
    FLAG_MOVED,
    FLAG_UP_ZERO,
    FLAG_DOWN_NEG
  } flag_t;

endpackage

// ----- hdl/axis_position_counter_bank.sv -----
// Axis position counter bank: four wrapping axis counts with movement flags
// and a scaled, saturated position per event.
// An accepted event passes the s1, s2 and s3 registers and the output register.
// Throughput: one event per cycle while out_stall lets the pipeline advance; the count
// update is a read-modify-write at accept, the 32x32 scale multiply has a stage of its own.
// Reset (rst, synchronous) clears counts, flags, scale registers and all valids.
module axis_position_counter_bank (
  input  logic                          clk,
  input  logic                          rst,
  // event channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    kind,
  input  logic [1:0]                    axis,
  input  logic signed [31:0]            new_count,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    axis_out,
  output logic signed [31:0]            count,
  output logic [1:0]                    flag,
  output logic signed [apcb_pkg::POS_W-1:0] position,
  output logic                          saturated,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [apcb_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import apcb_pkg::*;

  logic [SCALE_W-1:0]     scale [4];
  logic [COUNT_WIDTH-1:0] axis_counts [NUM_AXES];
  flag_t                  axis_flags [NUM_AXES];

  // pipeline registers
  logic                   s1_valid, s2_valid, s3_valid;
  logic [1:0]             s1_axis, s2_axis, s3_axis;
  logic                   s1_present, s2_present, s3_present;
  logic [COUNT_WIDTH-1:0] s1_count, s2_count, s3_count;
  flag_t                  s1_flag, s2_flag, s3_flag;
  logic [COUNT_WIDTH-1:0] s2_cmag;
  logic [SCALE_W-1:0]     s2_smag;
  logic                   s2_neg, s3_neg;
  logic [PROD_W-1:0]      s3_prod;

  logic                   adv1, adv2, adv3, adv4;
  logic                   accept;
  logic                   present;
  logic [COUNT_WIDTH-1:0] cnt_cur, count_next;
  flag_t                  flag_cur, flag_next;
  logic signed [63:0]     load_ext;
  logic [COUNT_WIDTH-1:0] cmag;
  logic [SCALE_W-1:0]     scale_sel, smag;
  logic                   sneg;
  logic [MAG_W-1:0]       mag;
  logic                   sat;
  logic signed [63:0]     count_ext;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign prdata = scale[paddr[3:2]];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) scale[i] <= '0;
    end else if (psel && penable && pwrite) begin
      scale[paddr[3:2]] <= pwdata;
    end
  end

  // ---------------------------------------------------------------- flow
  // A stage advances when it is empty or the stage after it advances.
  assign adv4     = !out_valid || !out_stall;
  assign adv3     = !s3_valid || adv4;
  assign adv2     = !s2_valid || adv3;
  assign adv1     = !s1_valid || adv2;
  assign in_stall = !adv1;
  assign accept   = in_valid && adv1;

  // ---------------------------------------------------------------- stage 1
  assign present  = 4'(axis) < 4'(NUM_AXES);
  assign load_ext = 64'(new_count);

  always_comb begin
    cnt_cur    = present ? axis_counts[axis] : '0;
    flag_cur   = present ? axis_flags[axis] : FLAG_CLEAR;
    count_next = cnt_cur;
    flag_next  = flag_cur;
    unique case (kind_t'(kind))
      KIND_INC: begin
        flag_next  = (cnt_cur == '1) ? FLAG_UP_ZERO : FLAG_MOVED;
        count_next = cnt_cur + 1'b1;
      end
      KIND_DEC: begin
        flag_next  = (cnt_cur == '0) ? FLAG_DOWN_NEG : FLAG_MOVED;
        count_next = cnt_cur - 1'b1;
      end
      KIND_ZERO:  count_next = '0;
      KIND_LOAD:  count_next = load_ext[COUNT_WIDTH-1:0];
      KIND_CLEAR: flag_next  = FLAG_CLEAR;
      KIND_READ:  ;
      default:    ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        axis_counts[i] <= '0;
        axis_flags[i]  <= FLAG_CLEAR;
      end
    end else if (accept && present) begin
      axis_counts[axis] <= count_next;
      axis_flags[axis]  <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_axis    <= axis;
      s1_present <= present;
      s1_count   <= count_next;
      s1_flag    <= flag_next;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // Split count and scale into magnitude and sign.
  assign cmag      = s1_count[COUNT_WIDTH-1] ? (~s1_count + 1'b1) : s1_count;
  assign scale_sel = scale[s1_axis];

  always_comb begin
    if (scale_sel == '0) begin
      smag = (s1_axis == ROTARY_AXIS) ? MIN_SCALE_ROTARY : MIN_SCALE_LINEAR;
      sneg = 1'b0;
    end else begin
      smag = scale_sel[SCALE_W-1] ? (~scale_sel + 1'b1) : scale_sel;
      sneg = scale_sel[SCALE_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_valid) begin
      s2_axis    <= s1_axis;
      s2_present <= s1_present;
      s2_count   <= s1_count;
      s2_flag    <= s1_flag;
      s2_cmag    <= cmag;
      s2_smag    <= smag;
      s2_neg     <= s1_count[COUNT_WIDTH-1] != sneg;
    end
  end

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3 && s2_valid) begin
      s3_axis    <= s2_axis;
      s3_present <= s2_present;
      s3_count   <= s2_count;
      s3_flag    <= s2_flag;
      s3_neg     <= s2_neg;
      s3_prod    <= PROD_W'(s2_cmag) * PROD_W'(s2_smag);
    end
  end

  // ---------------------------------------------------------------- stage 4
  // Clamp when the unshifted product reaches 1000000 display LSBs.
  assign sat       = s3_prod >= SAT_THRESHOLD;
  assign mag       = sat ? POS_LIMIT : s3_prod[16 +: MAG_W];
  assign count_ext = 64'(signed'(s3_count));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4 && s3_valid) begin
      axis_out <= s3_axis;
      if (s3_present) begin
        count     <= count_ext[31:0];
        flag      <= s3_flag;
        position  <= s3_neg ? -signed'(POS_W'(mag)) : signed'(POS_W'(mag));
        saturated <= sat;
      end else begin
        count     <= '0;
        flag      <= FLAG_CLEAR;
        position  <= '0;
        saturated <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/apcb_checker.sv -----
// Port-level checker for the axis position counter bank, bound to the top level.
// Depends on apcb_pkg and axis_position_counter_bank_defines.svh.
`include "axis_position_counter_bank_defines.svh"

module apcb_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [1:0]                        axis_out,
  input logic signed [31:0]                count,
  input logic [1:0]                        flag,
  input logic signed [apcb_pkg::POS_W-1:0] position,
  input logic                              saturated
);
  import apcb_pkg::*;

  logic signed [POS_W-1:0] lim_pos, lim_neg;

  assign lim_pos = signed'(POS_W'(POS_LIMIT));
  assign lim_neg = -lim_pos;

  // hold a stalled transaction
  `APCB_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(axis_out) && $stable(count) && $stable(flag) && $stable(position) && $stable(saturated))

  // position stays inside the display range
  `APCB_ASSERT_IMPLIES(a_pos_range, clk, rst, out_valid, position <= lim_pos && position >= lim_neg)

  // clamp reports the limit
  `APCB_ASSERT_IMPLIES(a_sat_limit, clk, rst, out_valid && saturated, position == lim_pos || position == lim_neg)

  // zero count scales to zero
  `APCB_ASSERT_IMPLIES(a_zero_pos, clk, rst, out_valid && count == 32'sd0, position == '0 && !saturated)

  // drop results across reset
  `APCB_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid)

endmodule

bind axis_position_counter_bank apcb_checker u_apcb_checker (.*);

// ----- tb/tb_axis_position_counter_bank.sv -----
// Self-checking testbench for axis_position_counter_bank: directed table, then random phases.
// Depends on apcb_pkg and the axis_position_counter_bank RTL; results checked by in-order scoreboard.
`timescale 1ns / 100ps

module tb_axis_position_counter_bank;
  import apcb_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_OFF_LEN  = 200;
  localparam int PHASE_ITEMS   = 220;
  localparam int RANDOM_PHASES = 5;

  // kind codes 6 and 7 are unused and behave as a read
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef enum logic [1:0] {
    REG_SCALE_X,
    REG_SCALE_Y,
    REG_SCALE_Z,
    REG_SCALE_R
  } scale_reg_t;

  typedef struct packed {
    logic [1:0]       axis_out;
    logic [31:0]      count;
    logic [1:0]       flag;
    logic [POS_W-1:0] position;
    logic             saturated;
  } readout_t;

  typedef struct packed {
    logic       is_write;
    scale_reg_t reg_sel;
    logic [2:0] kind;
    logic [1:0] axis;
    logic [31:0] value;
    logic       typed;
    readout_t   want;
  } dir_row_t;

  logic clk;
  logic rst = 1'b1;

  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [2:0]        kind = KIND_READ;
  logic [1:0]        axis = '0;
  logic signed [31:0] new_count = '0;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        axis_out;
  logic signed [31:0] count;
  logic [1:0]        flag;
  logic signed [POS_W-1:0] position;
  logic              saturated;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor state
  logic [31:0] axis_count [4];
  logic [1:0]  axis_flag  [4];
  logic [31:0] axis_scale [4];

  readout_t pending_readouts [$];
  dir_row_t dir_rows [$];

  int mismatches    = 0;
  int cycles        = 0;
  int src_idle_pct  = 25;
  int snk_stall_pct = 25;
  bit hold_off_req  = 1'b0;

  axis_position_counter_bank uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .axis      (axis),
    .new_count (new_count),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .axis_out  (axis_out),
    .count     (count),
    .flag      (flag),
    .position  (position),
    .saturated (saturated),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("mismatch in %s at cycle %0d: got %h, want %h", field, cycles, got, want);
  endtask

  // Count times scale, truncated toward zero and clamped to the display range.
  function automatic logic [POS_W-1:0] scaled_readout(input logic [31:0] cnt,
                                                      input logic [1:0] ax,
                                                      output logic sat);
    logic [32:0] cmag;
    logic [32:0] smag;
    logic [63:0] prod;
    logic [19:0] mag;
    logic        neg;
    cmag = cnt[31] ? (33'h1_0000_0000 - {1'b0, cnt}) : {1'b0, cnt};
    if (axis_scale[ax] == '0) begin
      smag = (ax == ROTARY_AXIS) ? {1'b0, MIN_SCALE_ROTARY} : {1'b0, MIN_SCALE_LINEAR};
      neg  = cnt[31];
    end else begin
      smag = axis_scale[ax][31] ? (33'h1_0000_0000 - {1'b0, axis_scale[ax]})
                                : {1'b0, axis_scale[ax]};
      neg  = cnt[31] ^ axis_scale[ax][31];
    end
    prod = 64'(cmag) * 64'(smag);
    sat  = (prod >= 64'(SAT_THRESHOLD));
    mag  = sat ? POS_LIMIT : prod[35:16];
    return neg ? -POS_W'(mag) : POS_W'(mag);
  endfunction

  function automatic readout_t advance_axis(input logic [2:0] k, input logic [1:0] a,
                                            input logic [31:0] nc);
    readout_t r;
    logic [31:0] c;
    logic        sat;
    c = axis_count[a];
    case (k)
      KIND_INC: begin
        axis_flag[a] = (c == '1) ? FLAG_UP_ZERO : FLAG_MOVED;
        c = c + 32'd1;
      end
      KIND_DEC: begin
        axis_flag[a] = (c == '0) ? FLAG_DOWN_NEG : FLAG_MOVED;
        c = c - 32'd1;
      end
      KIND_ZERO:  c = '0;
      KIND_LOAD:  c = nc;
      KIND_CLEAR: axis_flag[a] = FLAG_CLEAR;
      default: ;
    endcase
    axis_count[a] = c;
    r.axis_out  = a;
    r.count     = c;
    r.flag      = axis_flag[a];
    r.position  = scaled_readout(c, a, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic void add_event(input logic [2:0] k, input logic [1:0] a,
                                    input logic [31:0] nc);
    dir_row_t r;
    r = '0;
    r.kind  = k;
    r.axis  = a;
    r.value = nc;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_checked(input logic [2:0] k, input logic [1:0] a,
                                      input logic [31:0] nc, input logic [31:0] cnt,
                                      input logic [1:0] fl, input int pos, input logic sat);
    dir_row_t r;
    r = '0;
    r.kind  = k;
    r.axis  = a;
    r.value = nc;
    r.typed = 1'b1;
    r.want  = '{axis_out: a, count: cnt, flag: fl, position: POS_W'(pos), saturated: sat};
    dir_rows.push_back(r);
  endfunction

  function automatic void add_write(input scale_reg_t idx, input logic [31:0] v);
    dir_row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.reg_sel  = idx;
    r.value    = v;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [31:0] pick_count();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 35)      return 32'($urandom_range(0, 6)) - 32'd3;
    else if (sel < 65) return 32'($urandom_range(0, 4000)) - 32'd2000;
    else if (sel < 85) return $urandom;
    else if (sel < 93) return 32'h7FFF_FFFF - 32'($urandom_range(0, 3));
    else               return 32'h8000_0000 + 32'($urandom_range(0, 3));
  endfunction

  function automatic logic [31:0] pick_scale();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      4:       return 32'hFFFF_FFFF;
      5:       return 32'h0001_0000;
      6:       return 32'($urandom_range(0, 32'h60000)) - 32'h30000;
      7:       return 32'($urandom_range(1, 32'h2000));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_kind();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 30)      return KIND_INC;
    else if (sel < 55) return KIND_DEC;
    else if (sel < 67) return KIND_LOAD;
    else if (sel < 75) return KIND_ZERO;
    else if (sel < 83) return KIND_CLEAR;
    else if (sel < 93) return KIND_READ;
    else               return $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
  endfunction

  // Offer one transaction, hold it until accepted, then maybe idle for a burst.
  task automatic send_event(input logic [2:0] k, input logic [1:0] a, input logic [31:0] nc,
                            input logic typed, input readout_t want);
    readout_t predicted;
    in_valid  <= 1'b1;
    kind      <= k;
    axis      <= a;
    new_count <= nc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_axis(k, a, nc);
    pending_readouts.push_back(typed ? want : predicted);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic drain_readouts();
    in_valid <= 1'b0;
    while (pending_readouts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write, then read back the same register.
  task automatic write_scale(input scale_reg_t idx, input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    axis_scale[idx] = v;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== v) report_mismatch("register readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin : result_check
    readout_t got;
    readout_t want;
    if (!rst && out_valid && !out_stall) begin
      got = '{axis_out: axis_out, count: count, flag: flag, position: position,
              saturated: saturated};
      if (pending_readouts.size() == 0) begin
        report_mismatch("unexpected transaction", got, '0);
      end else begin
        want = pending_readouts.pop_front();
        if (got.axis_out !== want.axis_out)   report_mismatch("axis_out", got.axis_out, want.axis_out);
        if (got.count !== want.count)         report_mismatch("count", got.count, want.count);
        if (got.flag !== want.flag)           report_mismatch("flag", got.flag, want.flag);
        if (got.position !== want.position)   report_mismatch("position", got.position, want.position);
        if (got.saturated !== want.saturated) report_mismatch("saturated", got.saturated, want.saturated);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_sink
    int hold_cycles;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_OFF_LEN; hold_cycles++) @(posedge clk);
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 99) < snk_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    int phase;
    int n;
    int r;
    for (n = 0; n < 4; n++) begin
      axis_count[n] = '0;
      axis_flag[n]  = FLAG_CLEAR;
      axis_scale[n] = '0;
    end

    // reset scales: zero acts as the minimum scale
    add_checked(KIND_READ, 2'd0, 32'd0, 32'd0, FLAG_CLEAR, 0, 1'b0);
    add_checked(KIND_DEC, 2'd1, 32'd0, 32'hFFFF_FFFF, FLAG_DOWN_NEG, 0, 1'b0);
    add_checked(KIND_INC, 2'd1, 32'd0, 32'd0, FLAG_UP_ZERO, 0, 1'b0);
    add_checked(KIND_LOAD, 2'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, FLAG_CLEAR, 999999, 1'b1);
    add_checked(KIND_INC, 2'd2, 32'd0, 32'h8000_0000, FLAG_MOVED, -999999, 1'b1);
    add_checked(KIND_DEC, 2'd2, 32'd0, 32'h7FFF_FFFF, FLAG_MOVED, 999999, 1'b1);
    add_checked(KIND_CLEAR, 2'd2, 32'd0, 32'h7FFF_FFFF, FLAG_CLEAR, 999999, 1'b1);
    add_event(KIND_LOAD, 2'd3, 32'd1000);
    add_checked(KIND_ZERO, 2'd3, 32'hFFFF_FFFF, 32'd0, FLAG_CLEAR, 0, 1'b0);
    add_checked(KIND_SPARE_A, 2'd0, 32'hFFFF_FFFF, 32'd0, FLAG_CLEAR, 0, 1'b0);
    add_checked(KIND_SPARE_B, 2'd1, 32'h5555_AAAA, 32'd0, FLAG_UP_ZERO, 0, 1'b0);
    add_write(REG_SCALE_X, 32'h0001_0000);
    add_write(REG_SCALE_Y, 32'h7FFF_FFFF);
    add_write(REG_SCALE_Z, 32'h8000_0000);
    add_write(REG_SCALE_R, 32'hFFFF_FFFF);
    // saturation boundary at exactly one million display LSBs
    add_checked(KIND_LOAD, 2'd0, 32'd999999, 32'd999999, FLAG_CLEAR, 999999, 1'b0);
    add_checked(KIND_INC, 2'd0, 32'd0, 32'd1000000, FLAG_MOVED, 999999, 1'b1);
    add_checked(KIND_LOAD, 2'd0, -32'sd999999, -32'sd999999, FLAG_MOVED, -999999, 1'b0);
    add_checked(KIND_DEC, 2'd0, 32'd0, -32'sd1000000, FLAG_MOVED, -999999, 1'b1);
    add_event(KIND_LOAD, 2'd1, 32'd1);
    add_event(KIND_LOAD, 2'd1, 32'd30);
    add_event(KIND_LOAD, 2'd1, 32'd31);
    add_event(KIND_LOAD, 2'd2, 32'hFFFF_FFFF);
    add_event(KIND_INC, 2'd3, 32'd0);
    add_event(KIND_LOAD, 2'd3, 32'h8000_0000);
    add_event(KIND_DEC, 2'd1, 32'd0);
    add_event(KIND_READ, 2'd2, 32'd0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_write) begin
        drain_readouts();
        write_scale(dir_rows[i].reg_sel, dir_rows[i].value);
      end else begin
        send_event(dir_rows[i].kind, dir_rows[i].axis, dir_rows[i].value,
                   dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_readouts();
      for (r = 0; r < 4; r++) write_scale(scale_reg_t'(r), pick_scale());
      case (phase)
        0: begin src_idle_pct = 25; snk_stall_pct = 25; end
        1: begin src_idle_pct = 10; snk_stall_pct = 40; hold_off_req = 1'b1; end
        2: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        3: begin src_idle_pct = 50; snk_stall_pct = 50; end
        default: begin src_idle_pct = 0; snk_stall_pct = 0; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++)
        send_event(pick_kind(), 2'($urandom_range(0, 3)), pick_count(), 1'b0, '0);
    end

    drain_readouts();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
